FILE: hdl/gbe_pkg.sv
// ----------------------------------------------------------------------------
// gbe_pkg: shared definitions for the GOST block encryption core
// Round count, key word layout, S-box table and round key schedule.
// ----------------------------------------------------------------------------
package gbe_pkg;

    localparam int KEY_WORDS   = 8;
    localparam int ROUND_COUNT = 32;
    localparam int KEY_IDX_W   = $clog2(KEY_WORDS);
    localparam int ADDR_W      = KEY_IDX_W + 2;

    typedef logic [31:0] t_word;
    typedef logic [63:0] t_block;
    typedef t_word       t_key_array [KEY_WORDS];
    typedef logic [3:0]  t_sbox [8][16];

    // row 0 serves the top nibble, row 7 the bottom one
    localparam t_sbox SBOX = '{
        '{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
          4'd6,  4'd11, 4'd1,  4'd12, 4'd7,  4'd15, 4'd5,  4'd3},
        '{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
          4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
        '{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
          4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
        '{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
          4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3},
        '{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
          4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd3,  4'd11, 4'd2},
        '{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
          4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
        '{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
          4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
        '{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
          4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12}
    };

    // key words 0..7 three times, then 7..0
    function automatic int round_key_idx(input int round);
        int low;
        low = round % KEY_WORDS;
        return (round < ROUND_COUNT - KEY_WORDS) ? low : (KEY_WORDS - 1 - low);
    endfunction

endpackage

FILE: hdl/gost_block_encrypt.sv
// ----------------------------------------------------------------------------
// gost_block_encrypt: GOST 28147-89 block encryption, 32-round pipeline
// One register per round, from input accept to the output of the last round.
// Throughput: one block per cycle while i_ready stays high; each round cell frees as its item moves on.
// Reset (synchronous, active low) empties all cells and clears the key to 0.
// ----------------------------------------------------------------------------
module gost_block_encrypt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gbe_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [63:0]                i_plain_block,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [63:0]                o_cipher_block
);

    gbe_pkg::t_key_array keys;
    logic                chain_valid [gbe_pkg::ROUND_COUNT+1];
    logic                chain_ready [gbe_pkg::ROUND_COUNT+1];
    gbe_pkg::t_block     chain_block [gbe_pkg::ROUND_COUNT+1];
    gbe_pkg::t_block     last_block;

    gbe_key_regs u_key_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_keys  (keys)
    );

    assign chain_valid[0] = i_valid;
    assign chain_block[0] = i_plain_block;
    assign o_ready        = chain_ready[0];

    for (genvar g = 0; g < gbe_pkg::ROUND_COUNT; g++) begin : g_round
        localparam int KIDX = gbe_pkg::round_key_idx(g);
        gbe_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .o_ready (chain_ready[g]),
            .i_block (chain_block[g]),
            .i_key   (keys[KIDX]),
            .o_valid (chain_valid[g+1]),
            .i_ready (chain_ready[g+1]),
            .o_block (chain_block[g+1])
        );
    end

    assign chain_ready[gbe_pkg::ROUND_COUNT] = i_ready;
    assign last_block     = chain_block[gbe_pkg::ROUND_COUNT];
    assign o_valid        = chain_valid[gbe_pkg::ROUND_COUNT];
    // final N1 goes to the high half, N2 to the low half
    assign o_cipher_block = {last_block[31:0], last_block[63:32]};

endmodule

FILE: hdl/gbe_key_regs.sv
// ----------------------------------------------------------------------------
// gbe_key_regs: key register file
// Eight 32-bit key words written and read over the APB-style port.
// ----------------------------------------------------------------------------
module gbe_key_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [gbe_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output gbe_pkg::t_key_array       o_keys
);

    gbe_pkg::t_key_array            r_keys;
    logic [gbe_pkg::KEY_IDX_W-1:0]  w_idx;
    logic                           w_wr;

    assign w_idx  = paddr[gbe_pkg::ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = r_keys[w_idx];
    assign o_keys = r_keys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < gbe_pkg::KEY_WORDS; k++) begin
                r_keys[k] <= '0;
            end
        end else if (w_wr) begin
            r_keys[w_idx] <= pwdata;
        end
    end

endmodule

FILE: hdl/gbe_round_cell.sv
// ----------------------------------------------------------------------------
// gbe_round_cell: one Feistel round
// Key add, S-box substitution, rotate by 11, XOR and half swap, registered.
// ----------------------------------------------------------------------------
module gbe_round_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  gbe_pkg::t_block i_block,
    input  gbe_pkg::t_word  i_key,
    output logic            o_valid,
    input  logic            i_ready,
    output gbe_pkg::t_block o_block
);

    logic            r_valid;
    gbe_pkg::t_block r_block;
    gbe_pkg::t_block n_block;
    gbe_pkg::t_word  w_sum;
    gbe_pkg::t_word  w_sub;
    gbe_pkg::t_word  w_rot;
    logic            w_adv;

    // low half is N1, high half is N2
    assign w_sum = i_block[31:0] + i_key;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_sub[4*k +: 4] = gbe_pkg::SBOX[7-k][w_sum[4*k +: 4]];
        end
    end

    assign w_rot   = {w_sub[20:0], w_sub[31:21]};
    assign n_block = {i_block[31:0], w_rot ^ i_block[63:32]};

    // advance when empty or when the next cell takes the held item
    assign w_adv   = ~r_valid | i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_valid;
    assign o_block = r_block;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_block <= n_block;
        end
    end

endmodule
